// File: sv/page_table_mapper_with_frame_allocator_defines.svh
// shared assertion macros
`ifndef PAGE_TABLE_MAPPER_WITH_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_TABLE_MAPPER_WITH_FRAME_ALLOCATOR_DEFINES_SVH

// condition holds in the same cycle
`define PTM_ASSERT_NOW(label, cond, impl) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (impl)) \
		else $error("ptm assertion failed");

// condition holds in the following cycle
`define PTM_ASSERT_NEXT(label, cond, impl) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (impl)) \
		else $error("ptm assertion failed");

`endif

// File: sv/ptm_pkg.sv
`default_nettype none
package ptm_pkg;
	localparam logic [2:0] REQ_ALLOC = 3'd0;
	localparam logic [2:0] REQ_FREE  = 3'd1;
	localparam logic [2:0] REQ_MAP   = 3'd2;
	localparam logic [2:0] REQ_LOAD  = 3'd3;
	localparam logic [2:0] REQ_HEAD  = 3'd4;
	localparam logic [2:0] REQ_READ  = 3'd5;
	localparam logic [2:0] REQ_WRITE = 3'd6;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_NOFRAME = 3'd1;
	localparam logic [2:0] STAT_BADLVL  = 3'd2;
	localparam logic [2:0] STAT_MISALGN = 3'd3;
	localparam logic [2:0] STAT_RANGE   = 3'd4;

	localparam logic [1:0] CFG_ROOT  = 2'd0;
	localparam logic [1:0] CFG_COUNT = 2'd1;

	localparam logic [6:0] LIST_END = 7'd64;
	localparam logic [8:0] TBL_LAST = 9'd511;
	localparam logic [63:0] PG_PRESENT = 64'h1;
	localparam logic [63:0] PG_WRITE   = 64'h2;
	localparam logic [63:0] PG_PS      = 64'h80;
	localparam int REC_W = 24;
endpackage
`default_nettype wire

// File: sv/ptm_ram.sv
`default_nettype none
module ptm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: sv/page_table_mapper_with_frame_allocator.sv
// Page table mapper with a physical frame free list.
// Request channel: in_valid/in_stall with one port per request field; a
// transaction is taken at an edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall, one result per request, held in an
// output register until taken; the next request is taken while it waits.
// Config channel: cfg_valid/cfg_ready (always ready), index 0 root frame,
// index 1 frame count; write only while idle.
// A map walks the tables level by level; each missing table takes a frame
// from the free list, is zeroed by a sweep over all 512 entries through the
// single write port of the table memory, and is linked into its parent.
// One request is in work at a time; state lives in a frame record memory
// and a table memory, both with registered reads.
// Reset empties the free list and clears the config registers; record and
// table memory contents are undefined until written, no clearing pass.
// When out_stall is high the finished result holds and a later result waits.
`default_nettype none
`include "page_table_mapper_with_frame_allocator_defines.svh"
module page_table_mapper_with_frame_allocator #(
	parameter int FRAMES = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  req_type,
	input  wire  [47:0] virt_addr,
	input  wire  [51:0] phys_addr,
	input  wire  [1:0]  map_level,
	input  wire  [63:0] leaf_flags,
	input  wire  [6:0]  frame_index,
	input  wire         frame_state_in,
	input  wire  [15:0] frame_ref_in,
	input  wire  [6:0]  frame_next_in,
	input  wire  [8:0]  entry_index,
	input  wire  [63:0] entry_value,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        ok,
	output logic [2:0]  status,
	output logic [51:0] phys_result,
	output logic [63:0] read_value,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [6:0]  cfg_data
);
	localparam int FW  = $clog2(FRAMES);
	localparam int TBW = (FW > 6) ? FW : 6;
	localparam int TAW = FW + 9;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_POP, ST_WCHK, ST_WRD, ST_CLEAR, ST_LINK, ST_LEAF,
		ST_RD, ST_RESP
	} state_t;

	state_t        state_q;
	logic [5:0]    root_q;
	logic [6:0]    count_q;
	logic [6:0]    head_q;
	logic [2:0]    req_q;
	logic [47:0]   va_q;
	logic [51:0]   pa_q;
	logic [1:0]    level_q;
	logic [63:0]   flags_q;
	logic [6:0]    fidx_q;
	logic          fstate_q;
	logic [15:0]   fref_q;
	logic [6:0]    fnext_q;
	logic [8:0]    eidx_q;
	logic [63:0]   evalue_q;
	logic [TBW-1:0] table_q;
	logic [1:0]    lv_q;
	logic [FW-1:0] new_f_q;
	logic [8:0]    clr_cnt_q;
	logic [2:0]    st_q;
	logic [51:0]   pres_q;
	logic [63:0]   rval_q;
	logic          out_valid_q;
	logic          ok_q;
	logic [2:0]    status_q;
	logic [51:0]   phys_q;
	logic [63:0]   read_q;

	logic                        rec_we, rec_re;
	logic [FW-1:0]               rec_waddr, rec_raddr;
	logic [ptm_pkg::REC_W-1:0]   rec_wdata, rec_rdata;
	logic                        tbl_we, tbl_re;
	logic [TAW-1:0]              tbl_waddr, tbl_raddr;
	logic [63:0]                 tbl_wdata, tbl_rdata;

	logic          head_ok, fidx_ok, free_ok, table_ok, nf_ok, align_ok, present;
	logic [FW-1:0] head_f;
	logic [39:0]   free_f, nf;
	logic [8:0]    walk_idx, leaf_idx;
	logic [63:0]   leaf_entry, link_entry;

	function automatic logic [8:0] va_index(input logic [47:0] va, input logic [1:0] lv);
		logic [8:0] r;
		unique case (lv)
			2'd0: r = va[47:39];
			2'd1: r = va[38:30];
			2'd2: r = va[29:21];
			default: r = va[20:12];
		endcase
		return r;
	endfunction

	always_comb begin
		head_ok  = 32'(head_q) < 32'(FRAMES);
		head_f   = FW'(head_q);
		fidx_ok  = 32'(fidx_q) < 32'(FRAMES);
		free_f   = pa_q[51:12];
		free_ok  = (64'(free_f) < 64'(count_q)) && (64'(free_f) < 64'(FRAMES));
		table_ok = 32'(table_q) < 32'(FRAMES);
		present  = tbl_rdata[0];
		nf       = tbl_rdata[51:12];
		nf_ok    = 64'(nf) < 64'(FRAMES);
		walk_idx = va_index(va_q, lv_q);
		leaf_idx = va_index(va_q, level_q);
		unique case (level_q)
			2'd1: align_ok = (va_q[29:0] == '0) && (pa_q[29:0] == '0);
			2'd2: align_ok = (va_q[20:0] == '0) && (pa_q[20:0] == '0);
			default: align_ok = (va_q[11:0] == '0) && (pa_q[11:0] == '0);
		endcase
		leaf_entry = {12'd0, pa_q[51:12], 12'd0} | flags_q | ptm_pkg::PG_PRESENT
			| ((level_q != 2'd3) ? ptm_pkg::PG_PS : 64'd0);
		link_entry = (64'(new_f_q) << 12) | ptm_pkg::PG_PRESENT | ptm_pkg::PG_WRITE;
	end

	always_comb begin
		rec_we = 1'b0;
		rec_re = 1'b0;
		rec_waddr = head_f;
		rec_raddr = head_f;
		rec_wdata = {1'b1, 16'd1, ptm_pkg::LIST_END};
		tbl_we = 1'b0;
		tbl_re = 1'b0;
		tbl_waddr = {FW'(table_q), leaf_idx};
		tbl_raddr = {FW'(table_q), walk_idx};
		tbl_wdata = leaf_entry;
		unique case (state_q)
			ST_DECODE: begin
				unique case (req_q)
					ptm_pkg::REQ_ALLOC: rec_re = head_ok;
					ptm_pkg::REQ_FREE: begin
						rec_we = free_ok;
						rec_waddr = FW'(free_f);
						rec_wdata = {1'b0, 16'd0, head_q};
					end
					ptm_pkg::REQ_LOAD: begin
						rec_we = fidx_ok;
						rec_waddr = FW'(fidx_q);
						rec_wdata = {fstate_q, fref_q, fnext_q};
					end
					ptm_pkg::REQ_READ: begin
						tbl_re = fidx_ok;
						tbl_raddr = {FW'(fidx_q), eidx_q};
					end
					ptm_pkg::REQ_WRITE: begin
						tbl_we = fidx_ok;
						tbl_waddr = {FW'(fidx_q), eidx_q};
						tbl_wdata = evalue_q;
					end
					default: ;
				endcase
			end
			ST_POP:  rec_we = 1'b1;
			ST_WCHK: tbl_re = table_ok;
			ST_WRD:  rec_re = !present && head_ok;
			ST_CLEAR: begin
				tbl_we = 1'b1;
				tbl_waddr = {new_f_q, clr_cnt_q};
				tbl_wdata = 64'd0;
			end
			ST_LINK: begin
				tbl_we = 1'b1;
				tbl_waddr = {FW'(table_q), walk_idx};
				tbl_wdata = link_entry;
			end
			ST_LEAF: tbl_we = 1'b1;
			default: ;
		endcase
	end

	ptm_ram #(.WIDTH(ptm_pkg::REC_W), .DEPTH(FRAMES)) u_rec_ram (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.re(rec_re), .raddr(rec_raddr), .rdata(rec_rdata)
	);

	ptm_ram #(.WIDTH(64), .DEPTH(FRAMES * 512)) u_tbl_ram (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign ok = ok_q;
	assign status = status_q;
	assign phys_result = phys_q;
	assign read_value = read_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			root_q <= '0;
			count_q <= '0;
			head_q <= ptm_pkg::LIST_END;
			req_q <= '0;
			va_q <= '0;
			pa_q <= '0;
			level_q <= '0;
			flags_q <= '0;
			fidx_q <= '0;
			fstate_q <= 1'b0;
			fref_q <= '0;
			fnext_q <= '0;
			eidx_q <= '0;
			evalue_q <= '0;
			table_q <= '0;
			lv_q <= '0;
			new_f_q <= '0;
			clr_cnt_q <= '0;
			st_q <= '0;
			pres_q <= '0;
			rval_q <= '0;
			out_valid_q <= 1'b0;
			ok_q <= 1'b0;
			status_q <= '0;
			phys_q <= '0;
			read_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					ptm_pkg::CFG_ROOT:  root_q <= cfg_data[5:0];
					ptm_pkg::CFG_COUNT: count_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && (state_q != ST_RESP)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q <= req_type;
						va_q <= virt_addr;
						pa_q <= phys_addr;
						level_q <= map_level;
						flags_q <= leaf_flags;
						fidx_q <= frame_index;
						fstate_q <= frame_state_in;
						fref_q <= frame_ref_in;
						fnext_q <= frame_next_in;
						eidx_q <= entry_index;
						evalue_q <= entry_value;
						st_q <= ptm_pkg::STAT_OK;
						pres_q <= '0;
						rval_q <= '0;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					unique case (req_q)
						ptm_pkg::REQ_ALLOC: begin
							if (head_ok) begin
								state_q <= ST_POP;
							end else begin
								st_q <= ptm_pkg::STAT_NOFRAME;
								state_q <= ST_RESP;
							end
						end
						ptm_pkg::REQ_FREE: begin
							state_q <= ST_RESP;
							if (free_ok) head_q <= 7'(free_f);
							else st_q <= ptm_pkg::STAT_RANGE;
						end
						ptm_pkg::REQ_MAP: begin
							if (level_q == 2'd0) begin
								st_q <= ptm_pkg::STAT_BADLVL;
								state_q <= ST_RESP;
							end else if (!align_ok) begin
								st_q <= ptm_pkg::STAT_MISALGN;
								state_q <= ST_RESP;
							end else begin
								table_q <= TBW'(root_q);
								lv_q <= 2'd0;
								state_q <= ST_WCHK;
							end
						end
						ptm_pkg::REQ_HEAD: begin
							head_q <= fidx_q;
							state_q <= ST_RESP;
						end
						ptm_pkg::REQ_LOAD, ptm_pkg::REQ_WRITE: begin
							state_q <= ST_RESP;
							if (!fidx_ok) st_q <= ptm_pkg::STAT_RANGE;
						end
						ptm_pkg::REQ_READ: begin
							if (fidx_ok) begin
								state_q <= ST_RD;
							end else begin
								st_q <= ptm_pkg::STAT_RANGE;
								state_q <= ST_RESP;
							end
						end
						default: begin
							st_q <= ptm_pkg::STAT_BADLVL;
							state_q <= ST_RESP;
						end
					endcase
				end
				ST_RD: begin
					rval_q <= tbl_rdata;
					state_q <= ST_RESP;
				end
				ST_POP: begin
					head_q <= rec_rdata[6:0];
					new_f_q <= head_f;
					if (head_q == 7'd0) begin
						st_q <= ptm_pkg::STAT_NOFRAME;
						state_q <= ST_RESP;
					end else if (req_q == ptm_pkg::REQ_ALLOC) begin
						pres_q <= 52'(head_f) << 12;
						state_q <= ST_RESP;
					end else begin
						clr_cnt_q <= '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_WCHK: begin
					if (table_ok) begin
						state_q <= ST_WRD;
					end else begin
						st_q <= ptm_pkg::STAT_RANGE;
						state_q <= ST_RESP;
					end
				end
				ST_WRD: begin
					if (!present) begin
						if (head_ok) begin
							state_q <= ST_POP;
						end else begin
							st_q <= ptm_pkg::STAT_NOFRAME;
							state_q <= ST_RESP;
						end
					end else if (!nf_ok) begin
						st_q <= ptm_pkg::STAT_RANGE;
						state_q <= ST_RESP;
					end else begin
						table_q <= TBW'(nf);
						lv_q <= lv_q + 2'd1;
						state_q <= ((lv_q + 2'd1) == level_q) ? ST_LEAF : ST_WCHK;
					end
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 9'd1;
					if (clr_cnt_q == ptm_pkg::TBL_LAST) state_q <= ST_LINK;
				end
				ST_LINK: begin
					table_q <= TBW'(new_f_q);
					lv_q <= lv_q + 2'd1;
					state_q <= ((lv_q + 2'd1) == level_q) ? ST_LEAF : ST_WCHK;
				end
				ST_LEAF: state_q <= ST_RESP;
				ST_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						ok_q <= (st_q == ptm_pkg::STAT_OK);
						status_q <= st_q;
						phys_q <= pres_q;
						read_q <= rval_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PTM_ASSERT_NOW(a_ok_status, out_valid_q, ok_q == (status_q == ptm_pkg::STAT_OK))
	`PTM_ASSERT_NOW(a_no_tbl_wr_idle, state_q == ST_IDLE, !tbl_we && !rec_we)
	`PTM_ASSERT_NOW(a_clr_cnt_idle, state_q != ST_CLEAR, clr_cnt_q == 9'd0)
	`PTM_ASSERT_NEXT(a_accept_decode, in_valid && !in_stall, state_q == ST_DECODE)
endmodule
`default_nettype wire
